>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assertion helpers for the splat datapath
`define PSB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PSB_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> hw/rtl/psb_pkg.sv
package psb_pkg;
  localparam int SqrtSteps  = 19;
  localparam int RootW      = 19;
  localparam int RadW       = 36;
  localparam int DivSteps   = 34;
  localparam int NumW       = 34;
  localparam int DenW       = 16;
  localparam int Lat        = 3 + SqrtSteps + 1 + DivSteps + 2;

  typedef enum logic {
    CFG_GAIN   = 1'b0,
    CFG_WARMTH = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic        covered;
    logic        add;
    logic [23:0] dest;
    logic [16:0] s_r;
    logic [16:0] s_g;
    logic [16:0] s_b;
    logic [8:0]  op;
    logic [15:0] r8;
  } psb_side_t;

  typedef struct packed {
    logic [RadW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [RadW+1:0]  rad;
  } psb_sqrt_t;

  typedef struct packed {
    logic [DenW:0]    rem;
    logic [NumW-1:0]  num;
    logic [DenW-1:0]  den;
  } psb_div_t;

  function automatic logic [16:0] sat16(input logic [47:0] v);
    sat16 = (v > 48'd65536) ? 17'd65536 : v[16:0];
  endfunction
endpackage

>>> hw/rtl/particle_splat_blend_core.sv
// Fully pipelined splat blender: one pixel-particle pair accepted per clock while the
// output is not stalled. The pipeline has three front stages (deltas and colour
// products, squares and colour scaling, distance and coverage), 19 square-root cells,
// one alpha numerator stage, 34 alpha divider cells, then the alpha and blend stages.
// A stalled result freezes the whole chain and stalls the input.
`include "assert_macros.svh"
module particle_splat_blend_core
  import psb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_pixel_x,
  input  logic [11:0] in_pixel_y,
  input  logic signed [16:0] in_center_x,
  input  logic signed [16:0] in_center_y,
  input  logic [11:0] in_size,
  input  logic [8:0]  in_opacity,
  input  logic [35:0] in_source_rgb,
  input  logic        in_additive,
  input  logic        in_occluded,
  input  logic [23:0] in_dest_rgb,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_out_rgb,
  output logic        out_covered,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  logic [15:0] gain_r;
  logic signed [9:0] warmth_r;
  logic en;
  logic [Lat-1:0] vld_r;

  assign en        = !(out_stall && vld_r[Lat-1]);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[Lat-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= 16'd4096;
      warmth_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GAIN:   gain_r   <= cfg_data;
        CFG_WARMTH: warmth_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[Lat-2:0], in_valid};
  end

  // stage 0: deltas, colour products
  logic signed [17:0] dx_nxt, dy_nxt;
  logic signed [17:0] dx_r, dy_r;
  logic [11:0] rad_nxt, rad_r;
  logic signed [11:0] w_c;
  logic [11:0] fr, fb;
  logic [27:0] cg_r, cg_g, cg_b;
  logic [27:0] cg_r_r, cg_g_r, cg_b_r;
  logic [11:0] fr_r, fb_r;
  logic [8:0] op0_r;
  logic add0_r, occ0_r;
  logic [23:0] dest0_r;

  always_comb begin
    dx_nxt  = $signed({2'b00, in_pixel_x, 4'b1000}) - 18'(in_center_x);
    dy_nxt  = $signed({2'b00, in_pixel_y, 4'b1000}) - 18'(in_center_y);
    rad_nxt = (in_size < 12'd8) ? 12'd8 : in_size;
    if (warmth_r > 10'sd256)       w_c = 12'sd256;
    else if (warmth_r < -10'sd256) w_c = -12'sd256;
    else                           w_c = 12'(warmth_r);
    fr   = 12'(12'sd1024 + w_c);
    fb   = 12'(12'sd1024 - w_c);
    cg_r = 28'(in_source_rgb[35:24]) * 28'(gain_r);
    cg_g = 28'(in_source_rgb[23:12]) * 28'(gain_r);
    cg_b = 28'(in_source_rgb[11:0])  * 28'(gain_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= dx_nxt; dy_r <= dy_nxt; rad_r <= rad_nxt;
      cg_r_r <= cg_r; cg_g_r <= cg_g; cg_b_r <= cg_b;
      fr_r <= fr; fb_r <= fb; op0_r <= in_opacity;
      add0_r <= in_additive; occ0_r <= in_occluded; dest0_r <= in_dest_rgb;
    end
  end

  // stage 1: squares, colour scale
  logic [35:0] dxx_r, dyy_r;
  logic [23:0] rr_r;
  logic [39:0] pr, pb;
  psb_side_t s1_r;

  assign pr = 40'(cg_r_r) * 40'(fr_r);
  assign pb = 40'(cg_b_r) * 40'(fb_r);

  always_ff @(posedge clk) begin
    if (en) begin
      dxx_r <= 36'(dx_r * dx_r);
      dyy_r <= 36'(dy_r * dy_r);
      rr_r  <= 24'(rad_r) * 24'(rad_r);
      s1_r.covered <= !occ0_r;
      s1_r.add  <= add0_r;
      s1_r.dest <= dest0_r;
      s1_r.s_r  <= sat16(48'(pr >> 16));
      s1_r.s_g  <= sat16(48'(cg_g_r >> 6));
      s1_r.s_b  <= sat16(48'(pb >> 16));
      s1_r.op   <= op0_r;
      s1_r.r8   <= {rad_r, 4'b0000};
    end
  end

  // stage 2: d2 and coverage
  logic [36:0] d2;
  psb_side_t side2;
  psb_sqrt_t sq [0:SqrtSteps];
  psb_side_t sqs [0:SqrtSteps];
  assign d2 = 37'(dxx_r) + 37'(dyy_r);

  always_comb begin
    side2 = s1_r;
    side2.covered = s1_r.covered && (d2 <= 37'(rr_r));
  end

  // radicand is d2 << 8; d2 < 2^24 whenever the pixel is covered
  always_ff @(posedge clk) begin
    if (en) begin
      sq[0].rem  <= '0;
      sq[0].root <= '0;
      sq[0].rad  <= {d2[29:0], 8'h00};
      sqs[0]     <= side2;
    end
  end

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    psb_sqrt_cell u_cell (
      .clk(clk), .en(en), .in_s(sq[i]), .in_side(sqs[i]),
      .out_s(sq[i+1]), .out_side(sqs[i+1])
    );
  end

  // root is floor(sqrt(d2 << 8)), the distance in Q.8
  logic [RootW-1:0] d8;
  logic [15:0] d8c;
  psb_div_t dv [0:DivSteps];
  psb_side_t dvs [0:DivSteps];
  logic [NumW-1:0] num;

  assign d8  = sq[SqrtSteps].root;
  assign d8c = (d8 > RootW'(sqs[SqrtSteps].r8)) ? sqs[SqrtSteps].r8 : d8[15:0];
  assign num = {26'(sqs[SqrtSteps].op) * 26'(sqs[SqrtSteps].r8 - d8c), 8'h00};

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0].rem <= '0;
      dv[0].num <= num;
      dv[0].den <= sqs[SqrtSteps].r8;
      dvs[0]    <= sqs[SqrtSteps];
    end
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    psb_div_cell u_cell (
      .clk(clk), .en(en), .in_d(dv[j]), .in_side(dvs[j]),
      .out_d(dv[j+1]), .out_side(dvs[j+1])
    );
  end

  // blend: quotient = op*(r8-d8)*256/r8, alpha in Q.16
  logic [16:0] s_ch [0:2];
  logic [7:0]  d_ch [0:2];
  logic [7:0]  o_ch [0:2];
  logic [16:0] a_r;
  psb_side_t bs_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= sat16(48'(dv[DivSteps].num));
      bs_r <= dvs[DivSteps];
    end
  end

  assign s_ch[0] = bs_r.s_r;
  assign s_ch[1] = bs_r.s_g;
  assign s_ch[2] = bs_r.s_b;

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [41:0] src;
    logic [49:0] m;
    logic [17:0] hi;
    assign d_ch[c] = bs_r.dest[23-8*c -: 8];
    assign src = 42'(s_ch[c]) * 42'(a_r) * 42'd255;
    assign m = bs_r.add ? ({18'(d_ch[c]), 32'd0} + 50'(src))
             : (50'({26'(d_ch[c]) * (26'd65536 - 26'(a_r)), 16'd0}) + 50'(src));
    assign hi = 18'((m + 50'h80000000) >> 32);
    assign o_ch[c] = (hi > 18'd255) ? 8'd255 : hi[7:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_covered <= bs_r.covered;
      out_out_rgb <= bs_r.covered ? {o_ch[0], o_ch[1], o_ch[2]} : bs_r.dest;
    end
  end

  `PSB_ASSERT(a_stall_hold, clk, rst_n, out_stall && out_valid |=> out_valid, "result lost")
  `PSB_ASSERT(a_in_stall, clk, rst_n, in_stall |-> out_valid && out_stall, "spurious stall")
  `PSB_ASSERT(a_out_hold, clk, rst_n, out_stall && out_valid |=> $stable(out_out_rgb) && $stable(out_covered), "payload moved")
endmodule

>>> hw/rtl/psb_sqrt_cell.sv
module psb_sqrt_cell
  import psb_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  psb_sqrt_t in_s,
  input  psb_side_t in_side,
  output psb_sqrt_t out_s,
  output psb_side_t out_side
);
  psb_sqrt_t nxt;
  logic [RadW+1:0] trial;
  logic [RadW+1:0] cur;

  always_comb begin
    cur   = {in_s.rem, in_s.rad[RadW+1:RadW]};
    trial = cur - {{(RadW-RootW){1'b0}}, in_s.root, 2'b01};
    nxt.rad = {in_s.rad[RadW-1:0], 2'b00};
    if (!trial[RadW+1]) begin
      nxt.rem  = trial[RadW-1:0];
      nxt.root = {in_s.root[RootW-2:0], 1'b1};
    end else begin
      nxt.rem  = cur[RadW-1:0];
      nxt.root = {in_s.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_s    <= nxt;
      out_side <= in_side;
    end
  end
endmodule

>>> hw/rtl/psb_div_cell.sv
module psb_div_cell
  import psb_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  psb_div_t  in_d,
  input  psb_side_t in_side,
  output psb_div_t  out_d,
  output psb_side_t out_side
);
  psb_div_t nxt;
  logic [DenW+1:0] cur;
  logic [DenW+1:0] diff;

  always_comb begin
    cur  = {in_d.rem, in_d.num[NumW-1]};
    diff = cur - {2'b00, in_d.den};
    nxt.den = in_d.den;
    if (!diff[DenW+1]) begin
      nxt.rem = diff[DenW:0];
      nxt.num = {in_d.num[NumW-2:0], 1'b1};
    end else begin
      nxt.rem = cur[DenW:0];
      nxt.num = {in_d.num[NumW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d    <= nxt;
      out_side <= in_side;
    end
  end
endmodule

>>> sim/particle_splat_blend_core_tb.sv
`timescale 1ns / 100ps
module particle_splat_blend_core_tb;
  import psb_pkg::*;

  typedef struct packed {
    logic [11:0]        px;
    logic [11:0]        py;
    logic signed [16:0] cx;
    logic signed [16:0] cy;
    logic [11:0]        size;
    logic [8:0]         op;
    logic [35:0]        src;
    logic               add;
    logic               occ;
    logic [23:0]        dest;
  } splat_t;

  typedef struct packed {
    logic [23:0] rgb;
    logic        covered;
  } pixel_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [11:0] in_pixel_x;
  logic [11:0] in_pixel_y;
  logic signed [16:0] in_center_x;
  logic signed [16:0] in_center_y;
  logic [11:0] in_size;
  logic [8:0]  in_opacity;
  logic [35:0] in_source_rgb;
  logic        in_additive;
  logic        in_occluded;
  logic [23:0] in_dest_rgb;
  logic        out_valid;
  logic        out_stall;
  logic [23:0] out_out_rgb;
  logic        out_covered;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  particle_splat_blend_core uut (.*);

  logic [15:0] gain_reg;
  logic [9:0]  warmth_reg;
  pixel_t      pending_pixels[$];
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_left;
  int          errors;
  int          n_sent;
  int          n_checked;
  int          n_covered;
  int          n_cfg;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned clamp_unit(input longint unsigned v);
    return (v > 65536) ? 65536 : v;
  endfunction

  function automatic longint unsigned mix_channel(input longint unsigned d,
      input longint unsigned s, input longint unsigned a, input logic add);
    longint unsigned m;
    longint unsigned r;
    if (add) m = (d << 32) + s * 255 * a;
    else     m = ((d * (65536 - a)) << 16) + s * 255 * a;
    r = (m + (64'd1 << 31)) >> 32;
    return (r > 255) ? 255 : r;
  endfunction

  function automatic pixel_t predict_pixel(input splat_t it);
    pixel_t p;
    longint dx, dy, w;
    longint unsigned d2, r, d8, r8, a, fr, fb, c;
    longint unsigned s[3];
    logic signed [9:0] ws;
    dx = longint'(it.px) * 16 + 8 - longint'(it.cx);
    dy = longint'(it.py) * 16 + 8 - longint'(it.cy);
    d2 = dx * dx + dy * dy;
    r = (it.size < 8) ? 8 : it.size;
    if (d2 > r * r || it.occ) begin
      p.rgb = it.dest;
      p.covered = 1'b0;
      return p;
    end
    d8 = int_sqrt(d2 << 8);
    r8 = r << 4;
    if (d8 > r8) d8 = r8;
    a = clamp_unit(it.op * (r8 - d8) * 256 / r8);
    ws = warmth_reg;
    w = ws;
    if (w > 256) w = 256;
    if (w < -256) w = -256;
    fr = 1024 + w;
    fb = 1024 - w;
    c = it.src[35:24];
    s[0] = clamp_unit((c * gain_reg * fr) >> 16);
    c = it.src[23:12];
    s[1] = clamp_unit((c * gain_reg) >> 6);
    c = it.src[11:0];
    s[2] = clamp_unit((c * gain_reg * fb) >> 16);
    p.rgb[23:16] = 8'(mix_channel(it.dest[23:16], s[0], a, it.add));
    p.rgb[15:8]  = 8'(mix_channel(it.dest[15:8], s[1], a, it.add));
    p.rgb[7:0]   = 8'(mix_channel(it.dest[7:0], s[2], a, it.add));
    p.covered = 1'b1;
    return p;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // one transfer on the input channel
  task automatic send_splat(input splat_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_pixel_x = it.px;
    in_pixel_y = it.py;
    in_center_x = it.cx;
    in_center_y = it.cy;
    in_size = it.size;
    in_opacity = it.op;
    in_source_rgb = it.src;
    in_additive = it.add;
    in_occluded = it.occ;
    in_dest_rgb = it.dest;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_pixels.push_back(predict_pixel(it));
    n_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (Lat + 10) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_GAIN) gain_reg = v;
    else warmth_reg = v[9:0];
    n_cfg++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic splat_t make_splat(input logic [11:0] px, input logic [11:0] py,
      input int cx, input int cy, input logic [11:0] size, input logic [8:0] op,
      input logic [35:0] src, input logic add, input logic occ, input logic [23:0] dest);
    splat_t it;
    it.px = px; it.py = py; it.cx = 17'(cx); it.cy = 17'(cy); it.size = size; it.op = op;
    it.src = src; it.add = add; it.occ = occ; it.dest = dest;
    return it;
  endfunction

  function automatic splat_t random_splat;
    splat_t it;
    int rad, cx, cy;
    it.px = 12'($urandom);
    it.py = 12'($urandom);
    it.cx = 17'($urandom);
    it.cy = 17'($urandom);
    it.size = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(80));
    it.op = 9'($urandom);
    it.src = 36'({$urandom, $urandom});
    it.add = 1'($urandom);
    it.occ = ($urandom_range(7) == 0);
    it.dest = 24'($urandom);
    if ($urandom_range(3) != 0) begin
      // centre placed within reach of the pixel
      rad = (it.size < 8) ? 8 : int'(it.size);
      cx = int'(it.px) * 16 + 8 + $urandom_range(2 * rad) - rad;
      cy = int'(it.py) * 16 + 8 + $urandom_range(2 * rad) - rad;
      if (cx <= 65535 && cy <= 65535) begin
        it.cx = 17'(cx);
        it.cy = 17'(cy);
      end
    end
    return it;
  endfunction

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected transfer", int'(out_out_rgb), 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_out_rgb !== want.rgb)
          report_mismatch("out_rgb", int'(out_out_rgb), int'(want.rgb));
        if (out_covered !== want.covered)
          report_mismatch("covered", int'(out_covered), int'(want.covered));
        n_checked++;
        if (want.covered) n_covered++;
      end
    end
  end

  task automatic test_directed_edges;
    send_splat(make_splat(0, 0, 8, 8, 0, 511, 36'hFFFFFFFFF, 0, 0, 24'h000000));
    send_splat(make_splat(0, 0, 8, 8, 0, 0, 36'hFFFFFFFFF, 0, 0, 24'hFFFFFF));
    send_splat(make_splat(0, 0, 8, 8, 7, 256, 36'h400400400, 1, 0, 24'h808080));
    send_splat(make_splat(4095, 4095, 65535, 65535, 4095, 511, 36'h0, 0, 0, 24'hFFFFFF));
    send_splat(make_splat(0, 0, -65536, -65536, 4095, 511, 36'hFFFFFFFFF, 1, 0, 24'h0));
    send_splat(make_splat(4095, 0, 65535, -65536, 4095, 300, 36'hABC123DEF, 0, 0, 24'h123456));
    send_splat(make_splat(100, 100, 1608 + 64, 1608, 64, 511, 36'h800800800, 0, 0, 24'h0));
    send_splat(make_splat(100, 100, 1608 + 65, 1608, 64, 511, 36'h800800800, 0, 0, 24'h0));
    send_splat(make_splat(100, 100, 1608, 1608, 64, 511, 36'hFFF000FFF, 0, 1, 24'hA5A5A5));
    send_splat(make_splat(100, 100, 1608, 1608, 64, 511, 36'hFFFFFFFFF, 1, 0, 24'hFFFFFF));
    send_splat(make_splat(100, 100, 1600, 1616, 40, 128, 36'h3FF3FF3FF, 0, 0, 24'hFF00FF));
    send_splat(make_splat(2048, 1024, 32776, 16392, 3, 200, 36'h555AAA555, 1, 0, 24'h0F0F0F));
    send_splat(make_splat(7, 9, 120, 152, 8, 511, 36'hFFF000000, 0, 0, 24'h00FF00));
  endtask

  task automatic test_random(input int count);
    repeat (count) send_splat(random_splat());
  endtask

  task automatic test_settings_sweep;
    logic [15:0] gains[6];
    logic [15:0] warms[6];
    gains = '{16'd0, 16'd65535, 16'd4096, 16'd12345, 16'd8000, 16'd2048};
    warms = '{16'h0100, 16'h0300, 16'h03FF, 16'h01FF, 16'h0200, 16'hFC00};
    for (int k = 0; k < 6; k++) begin
      if (k < 2) begin
        send_idle_pct = 29; recv_stall_pct = 84;
      end else if (k < 4) begin
        send_idle_pct = 84; recv_stall_pct = 29;
      end else begin
        send_idle_pct = 0; recv_stall_pct = 0;
      end
      drain();
      write_reg(CFG_GAIN, gains[k]);
      write_reg(CFG_WARMTH, warms[k]);
      test_random(140);
    end
  endtask

  task automatic test_backpressure;
    drain();
    write_reg(CFG_GAIN, 16'd5000);
    write_reg(CFG_WARMTH, 16'h0080);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 300;
    test_random(90);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel_x = '0; in_pixel_y = '0; in_center_x = '0; in_center_y = '0;
    in_size = '0; in_opacity = '0; in_source_rgb = '0; in_additive = 1'b0;
    in_occluded = 1'b0; in_dest_rgb = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0; cfg_index = CFG_GAIN; cfg_data = '0;
    gain_reg = 16'd4096; warmth_reg = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_left = 0;
    errors = 0; n_sent = 0; n_checked = 0; n_covered = 0; n_cfg = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_edges();
    test_settings_sweep();
    test_backpressure();
    drain();
    $display("Covered %0d transfers in, %0d checked (%0d blended), %0d register writes,",
             n_sent, n_checked, n_covered, n_cfg);
    $display("gain and warmth extremes, both idling patterns and a long output hold.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end
endmodule
